// File: sv/imu_complementary_orientation_assert.svh
// Assertion macros for the orientation block
`ifndef IMU_COMPLEMENTARY_ORIENTATION_ASSERT_SVH
`define IMU_COMPLEMENTARY_ORIENTATION_ASSERT_SVH

// condition implies expression in the same cycle
`define ICO_ASSERT_SAME(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("ico check failed");

// condition implies expression in the next cycle
`define ICO_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("ico check failed");

`endif

// File: sv/ico_pkg.sv
package ico_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int REG_IDX_W = 3;
  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd62259;

  localparam logic [REG_IDX_W-1:0] REG_GYRO_OFFSET_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GYRO_OFFSET_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GYRO_OFFSET_Z  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_OFFSET_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_OFFSET_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_OFFSET_Z = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BLEND_WEIGHT   = 3'd6;

  typedef struct packed {
    logic signed [15:0] gyro_raw_x;
    logic signed [15:0] gyro_raw_y;
    logic signed [15:0] gyro_raw_z;
    logic signed [15:0] accel_raw_x;
    logic signed [15:0] accel_raw_y;
    logic signed [15:0] accel_raw_z;
    logic [15:0]        elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pitch_deg;
    logic signed [31:0] roll_deg;
    logic signed [31:0] yaw_deg;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [15:0]        ms;
  } diff_t;

  typedef struct packed {
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    logic [15:0] gyro_z;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
  } offsets_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // atan(2^-i) in degrees, Q24, rounded half up to frac fraction bits
  function automatic logic [31:0] atan_entry(input logic [4:0] i, input int frac);
    logic [32:0] t;
    int s;
    s = 24 - frac;
    unique case (i)
      5'd0:  t = 33'd754974720;
      5'd1:  t = 33'd445687602;
      5'd2:  t = 33'd235489088;
      5'd3:  t = 33'd119537938;
      5'd4:  t = 33'd60000934;
      5'd5:  t = 33'd30029717;
      5'd6:  t = 33'd15018523;
      5'd7:  t = 33'd7509720;
      5'd8:  t = 33'd3754917;
      5'd9:  t = 33'd1877466;
      5'd10: t = 33'd938734;
      5'd11: t = 33'd469367;
      5'd12: t = 33'd234684;
      5'd13: t = 33'd117342;
      5'd14: t = 33'd58671;
      5'd15: t = 33'd29335;
      5'd16: t = 33'd14668;
      5'd17: t = 33'd7334;
      5'd18: t = 33'd3667;
      5'd19: t = 33'd1833;
      5'd20: t = 33'd917;
      5'd21: t = 33'd458;
      5'd22: t = 33'd229;
      5'd23: t = 33'd115;
      default: t = 33'd0;
    endcase
    if (s > 0) t = (t + (33'd1 << (s - 1))) >> s;
    return t[31:0];
  endfunction

endpackage

// File: sv/ico_front.sv
module ico_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ico_pkg::in_item_t   in_data,
  input  ico_pkg::offsets_t   offs,
  output logic                q_valid,
  output ico_pkg::diff_t      q_data,
  input  logic                q_pop
);

  ico_pkg::diff_t fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  ico_pkg::diff_t item;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = fifo[rd_ptr];

  // offsets wrap to 16 bits
  always_comb begin
    item.gx = in_data.gyro_raw_x - offs.gyro_x;
    item.gy = in_data.gyro_raw_y - offs.gyro_y;
    item.gz = in_data.gyro_raw_z - offs.gyro_z;
    item.ax = in_data.accel_raw_x - offs.accel_x;
    item.ay = in_data.accel_raw_y - offs.accel_y;
    item.az = in_data.accel_raw_z - offs.accel_z;
    item.ms = in_data.elapsed_ms;
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/ico_back.sv
module ico_back #(
  parameter int CORDIC_STEPS    = ico_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ico_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        weight,
  input  logic               q_valid,
  input  ico_pkg::diff_t     q_data,
  output logic               q_pop,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output ico_pkg::out_item_t out_data
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int NW = F + 32;
  localparam int NC = (NW + 15) / 16;
  localparam int DW = NC * 16;
  localparam int ZW = F + 10;
  localparam int CW = 36;
  localparam int BW = (ZW + 19 > 50) ? ZW + 19 : 50;
  localparam int DCW = $clog2(NC);
  localparam int IW = $clog2(CORDIC_STEPS);

  // 131000 = 8 * 16375; reciprocal is floor(2^30 / 16375)
  localparam logic [16:0] DIV_D     = 17'd131000;
  localparam logic [16:0] DIV_RECIP = 17'd65572;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GMUL  = 4'd1;
  localparam logic [3:0] S_GDIV  = 4'd2;
  localparam logic [3:0] S_GACC  = 4'd3;
  localparam logic [3:0] S_CINIT = 4'd4;
  localparam logic [3:0] S_CITER = 4'd5;
  localparam logic [3:0] S_BMULG = 4'd6;
  localparam logic [3:0] S_BMULA = 4'd7;
  localparam logic [3:0] S_BSUM  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [1:0] k;
  logic       c;
  logic [DCW-1:0] cnt;
  logic           ph;
  logic [IW-1:0]  it;
  logic [DW-1:0]  num;
  logic [16:0]    rem;
  logic [16:0]    qe;
  logic           neg;
  logic signed [31:0] pitch, roll, yaw, gp, gr;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic signed [48:0]    prod_g;
  logic signed [ZW+17:0] prod_a;

  logic signed [16:0] d;
  logic [16:0]        mag;
  logic [32:0]        m;
  logic [DW-1:0]      num_init;
  logic [32:0]        part;
  logic [46:0]        est;
  logic [33:0]        pr;
  logic               fix;
  logic [15:0]        qdig;
  logic [16:0]        rem_n;
  logic signed [31:0] ang_sel;
  logic signed [DW:0] qv;
  logic signed [DW:0] gsum;
  logic signed [16:0] y0, x0;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] e;
  logic signed [ZW-1:0] half_turn;
  logic signed [48:0]    pg_n;
  logic signed [ZW+17:0] pa_n;
  logic signed [BW-1:0]  bsum;
  logic signed [31:0]    bres;

  always_comb begin
    unique case (k)
      2'd0:    d = -17'(q_data.gy);
      2'd1:    d = 17'(q_data.gx);
      default: d = 17'(q_data.gz);
    endcase
    mag      = d[16] ? 17'(-d) : 17'(d);
    m        = 33'(mag) * 33'(q_data.ms);
    num_init = DW'({m, {F{1'b0}}}) + DW'(65500);

    // one 16-bit digit of the long division by 131000
    part  = {rem, num[DW-1 -: 16]};
    est   = 47'(part[32:3]) * 47'(DIV_RECIP);
    pr    = 34'(part) - 34'(qe) * 34'(DIV_D);
    fix   = (pr >= 34'(DIV_D));
    qdig  = fix ? 16'(qe + 17'd1) : qe[15:0];
    rem_n = fix ? 17'(pr - 34'(DIV_D)) : pr[16:0];

    unique case (k)
      2'd0:    ang_sel = pitch;
      2'd1:    ang_sel = roll;
      default: ang_sel = yaw;
    endcase
    qv   = $signed({1'b0, num});
    gsum = (DW+1)'(ang_sel) + (neg ? -qv : qv);

    y0 = c ? 17'(q_data.ay) : -17'(q_data.ax);
    x0 = 17'(q_data.az);
    xs = cx >>> it;
    ys = cy >>> it;
    e  = ZW'($signed({1'b0, ico_pkg::atan_entry(5'(it), F)}));
    half_turn = ZW'(180) <<< F;

    pg_n = $signed({1'b0, weight}) * (c ? gr : gp);
    pa_n = $signed({1'b0, 17'd65536 - 17'(weight)}) * cz;
    bsum = BW'(prod_g) + BW'(prod_a) + BW'(32768);
    bres = ico_pkg::sat32(64'(bsum >>> 16));
  end

  assign q_pop = (state == S_DONE);
  assign busy  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pitch     <= '0;
      roll      <= '0;
      yaw       <= '0;
      k         <= '0;
      c         <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && !out_valid) begin
            k     <= 2'd0;
            state <= S_GMUL;
          end
        end
        S_GMUL: begin
          num   <= num_init;
          rem   <= '0;
          neg   <= d[16];
          cnt   <= '0;
          ph    <= 1'b0;
          state <= S_GDIV;
        end
        S_GDIV: begin
          if (!ph) begin
            qe <= est[46:30];
            ph <= 1'b1;
          end else begin
            num <= {num[DW-17:0], qdig};
            rem <= rem_n;
            cnt <= cnt + DCW'(1);
            ph  <= 1'b0;
            if (cnt == DCW'(NC - 1)) state <= S_GACC;
          end
        end
        S_GACC: begin
          unique case (k)
            2'd0:    gp  <= ico_pkg::sat32(64'(gsum));
            2'd1:    gr  <= ico_pkg::sat32(64'(gsum));
            default: yaw <= ico_pkg::sat32(64'(gsum));
          endcase
          if (k == 2'd2) begin
            c     <= 1'b0;
            state <= S_CINIT;
          end else begin
            k     <= k + 2'd1;
            state <= S_GMUL;
          end
        end
        S_CINIT: begin
          it <= '0;
          if (x0 == 17'sd0 && y0 == 17'sd0) begin
            cx <= '0;
            cy <= '0;
            cz <= '0;
          end else if (x0 < 0) begin
            cx <= CW'(-x0) <<< 16;
            cy <= CW'(-y0) <<< 16;
            cz <= (y0 >= 0) ? half_turn : -half_turn;
          end else begin
            cx <= CW'(x0) <<< 16;
            cy <= CW'(y0) <<< 16;
            cz <= '0;
          end
          state <= S_CITER;
        end
        S_CITER: begin
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + e;
          end else if (cy < 0) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - e;
          end
          it <= it + 1'b1;
          if (it == IW'(CORDIC_STEPS - 1)) state <= S_BMULG;
        end
        S_BMULG: begin
          prod_g <= pg_n;
          state  <= S_BMULA;
        end
        S_BMULA: begin
          prod_a <= pa_n;
          state  <= S_BSUM;
        end
        S_BSUM: begin
          if (c) begin
            roll  <= bres;
            state <= S_DONE;
          end else begin
            pitch <= bres;
            c     <= 1'b1;
            state <= S_CINIT;
          end
        end
        S_DONE: begin
          out_valid          <= 1'b1;
          out_data.pitch_deg <= pitch;
          out_data.roll_deg  <= roll;
          out_data.yaw_deg   <= yaw;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/imu_complementary_orientation.sv
// Complementary-filter pitch/roll/yaw estimator. Each item carries raw gyro and
// accelerometer triples and the elapsed milliseconds; one result item with Q16.16
// degree angles comes back per item. A two-item input queue takes items while the
// back end works. The back end runs one item at a time: three gyro increments, each a
// long division by 131000 in 16-bit digits (a reciprocal estimate then one correction
// per digit), then for pitch and roll each a CORDIC atan2 and a blend (gyro product,
// accelerometer product, rounded sum), between a start state and a hand-off state.
// Configuration writes are always ready; write only while the block is idle.
`include "imu_complementary_orientation_assert.svh"

module imu_complementary_orientation #(
  parameter int CORDIC_STEPS    = ico_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ico_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ico_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ico_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ico_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);

  ico_pkg::offsets_t offs;
  logic [15:0]       weight;
  logic              q_valid;
  logic              q_pop;
  logic              back_busy;
  ico_pkg::diff_t    q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offs   <= '0;
      weight <= ico_pkg::BLEND_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ico_pkg::REG_GYRO_OFFSET_X:  offs.gyro_x  <= cfg_data;
        ico_pkg::REG_GYRO_OFFSET_Y:  offs.gyro_y  <= cfg_data;
        ico_pkg::REG_GYRO_OFFSET_Z:  offs.gyro_z  <= cfg_data;
        ico_pkg::REG_ACCEL_OFFSET_X: offs.accel_x <= cfg_data;
        ico_pkg::REG_ACCEL_OFFSET_Y: offs.accel_y <= cfg_data;
        ico_pkg::REG_ACCEL_OFFSET_Z: offs.accel_z <= cfg_data;
        ico_pkg::REG_BLEND_WEIGHT:   weight       <= cfg_data;
        default: ;
      endcase
    end
  end

  ico_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .offs     (offs),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  ico_back #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .weight    (weight),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ICO_ASSERT_SAME(a_busy_has_item, back_busy, q_valid)
  `ICO_ASSERT_NEXT(a_pop_fills_out, q_pop, out_valid)
  `ICO_ASSERT_NEXT(a_out_drains, out_valid && !out_stall, !out_valid)

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ico_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ico_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ico_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  imu_complementary_orientation dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [15:0] offs [0:6];
  logic signed [31:0] pitch_st, roll_st, yaw_st;
  ico_pkg::out_item_t expected_angles [$];
  ico_pkg::in_item_t pending_items [$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint offset_diff(logic [15:0] raw, logic [15:0] off);
    logic signed [15:0] d;
    d = raw - off;
    return longint'(d);
  endfunction

  function automatic longint atan_deg(int i);
    longint q [0:15] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                         30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                         469367, 234684, 117342, 58671, 29335};
    return (q[i] + (64'sd1 <<< (23 - FRAC))) >>> (24 - FRAC);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0 ? 180 : -180) * (64'sd1 <<< FRAC);
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += atan_deg(i);
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z -= atan_deg(i);
      end
    end
    return z;
  endfunction

  function automatic longint rate_step(longint d, logic [15:0] ms);
    longint m, q;
    m = (d < 0 ? -d : d) * longint'({1'b0, ms});
    q = ((m <<< FRAC) + 65500) / 131000;
    return d < 0 ? -q : q;
  endfunction

  function automatic logic signed [31:0] mix(logic signed [31:0] g, longint a,
                                            logic [15:0] w);
    longint s;
    s = longint'({1'b0, w}) * g + (65536 - longint'({1'b0, w})) * a;
    return clamp32(floor_sh(s + 32768, 16));
  endfunction

  task automatic predict_orientation(ico_pkg::in_item_t it);
    longint gx, gy, gz, ax, ay, az;
    logic signed [31:0] gp, gr;
    ico_pkg::out_item_t r;
    gx = offset_diff(it.gyro_raw_x, offs[0]);
    gy = offset_diff(it.gyro_raw_y, offs[1]);
    gz = offset_diff(it.gyro_raw_z, offs[2]);
    ax = offset_diff(it.accel_raw_x, offs[3]);
    ay = offset_diff(it.accel_raw_y, offs[4]);
    az = offset_diff(it.accel_raw_z, offs[5]);
    gp = clamp32(longint'(pitch_st) + rate_step(-gy, it.elapsed_ms));
    gr = clamp32(longint'(roll_st) + rate_step(gx, it.elapsed_ms));
    yaw_st = clamp32(longint'(yaw_st) + rate_step(gz, it.elapsed_ms));
    pitch_st = mix(gp, vector_angle(-ax, az), offs[6]);
    roll_st = mix(gr, vector_angle(ay, az), offs[6]);
    r.pitch_deg = pitch_st;
    r.roll_deg = roll_st;
    r.yaw_deg = yaw_st;
    expected_angles.push_back(r);
  endtask

  // input and output-stall driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet && $urandom_range(99) < 12;
    end
  end

  // input acceptance and result monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      predict_orientation(in_data);
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        ico_pkg::out_item_t e;
        e = expected_angles.pop_front();
        if (e.pitch_deg !== out_data.pitch_deg) begin
          $display("%0t: pitch expected %0d actual %0d", $time, e.pitch_deg,
                   out_data.pitch_deg);
          errors++;
        end
        if (e.roll_deg !== out_data.roll_deg) begin
          $display("%0t: roll expected %0d actual %0d", $time, e.roll_deg,
                   out_data.roll_deg);
          errors++;
        end
        if (e.yaw_deg !== out_data.yaw_deg) begin
          $display("%0t: yaw expected %0d actual %0d", $time, e.yaw_deg,
                   out_data.yaw_deg);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[imu_complementary_orientation] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [ico_pkg::REG_IDX_W-1:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    offs[idx] = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_angles.size() > 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(400)) - 200);
      3: return 16'(int'($urandom_range(40000)) - 20000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ico_pkg::in_item_t rnd_item();
    ico_pkg::in_item_t it;
    it.gyro_raw_x = rnd16();
    it.gyro_raw_y = rnd16();
    it.gyro_raw_z = rnd16();
    it.accel_raw_x = rnd16();
    it.accel_raw_y = rnd16();
    it.accel_raw_z = $urandom_range(3) == 0 ? 16'h0 : rnd16();
    case ($urandom_range(3))
      0: it.elapsed_ms = 16'($urandom);
      1: it.elapsed_ms = 16'hffff;
      default: it.elapsed_ms = 16'($urandom_range(20));
    endcase
    return it;
  endfunction

  function automatic ico_pkg::in_item_t mk(logic [15:0] g, logic [15:0] ax,
                                           logic [15:0] ay, logic [15:0] az,
                                           logic [15:0] ms);
    ico_pkg::in_item_t it;
    it.gyro_raw_x = g; it.gyro_raw_y = g; it.gyro_raw_z = g;
    it.accel_raw_x = ax; it.accel_raw_y = ay; it.accel_raw_z = az;
    it.elapsed_ms = ms;
    return it;
  endfunction

  initial begin
    offs[0] = '0; offs[1] = '0; offs[2] = '0;
    offs[3] = '0; offs[4] = '0; offs[5] = '0;
    offs[6] = ico_pkg::BLEND_WEIGHT_RST;
    pitch_st = '0; roll_st = '0; yaw_st = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero vectors, half-turn, saturation, extremes
    pending_items.push_back(mk(16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    pending_items.push_back(mk(16'h0, 16'h0, 16'h0, 16'h8000, 16'd10));
    pending_items.push_back(mk(16'h0, 16'h7fff, 16'h0, 16'h8000, 16'd10));
    pending_items.push_back(mk(16'h0, 16'h8000, 16'h7fff, 16'h7fff, 16'd1));
    pending_items.push_back(mk(16'h7fff, 16'h1, 16'hffff, 16'h0, 16'hffff));
    pending_items.push_back(mk(16'h8000, 16'hffff, 16'h1, 16'hffff, 16'hffff));
    for (int i = 0; i < 6; i++)
      pending_items.push_back(mk(16'h8000, 16'h0, 16'h0, 16'h0, 16'hffff));
    for (int i = 0; i < 6; i++)
      pending_items.push_back(mk(16'h7fff, 16'h0, 16'h0, 16'h0, 16'hffff));
    pending_items.push_back(mk(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd7));
    drain();

    write_reg(ico_pkg::REG_BLEND_WEIGHT, 16'd0);
    write_reg(ico_pkg::REG_ACCEL_OFFSET_X, 16'h8000);
    write_reg(ico_pkg::REG_ACCEL_OFFSET_Z, 16'h7fff);
    pending_items.push_back(mk(16'h0, 16'h7fff, 16'h0, 16'h8000, 16'd5));
    pending_items.push_back(mk(16'h0, 16'h0, 16'h0, 16'h0, 16'd5));
    drain();
    write_reg(ico_pkg::REG_BLEND_WEIGHT, 16'hffff);
    pending_items.push_back(mk(16'h1234, 16'h0, 16'h0, 16'h0, 16'd5));
    drain();

    // random phases with differing register settings
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 7; r++)
        write_reg(r[ico_pkg::REG_IDX_W-1:0], ph == 0 ? 16'h0 :
                  (r == 6 ? (ph == 1 ? 16'hffff : 16'($urandom))
                          : ($urandom_range(1) ? rnd16() : 16'($urandom_range(60)))));
      quiet = (ph == 3);
      for (int i = 0; i < 140; i++) pending_items.push_back(rnd_item());
      drain();
    end
    write_reg(ico_pkg::REG_BLEND_WEIGHT, ico_pkg::BLEND_WEIGHT_RST);

    if (errors == 0) begin
      $display("[imu_complementary_orientation] OK");
    end else begin
      $display("[imu_complementary_orientation] ERROR");
    end
    $finish;
  end
endmodule
